@@ sv/mhnl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhnl_pkg: shared types and constants for the held-note list
// Sizes of the cell row, action codes and the per-cell control beat.
// ----------------------------------------------------------------------------
package mhnl_pkg;

  localparam int unsigned MaxNotes = 10;  // cells in the row, 1..15
  localparam int unsigned CntW     = $clog2(MaxNotes + 1);

  localparam logic [7:0] NoteOnStatus = 8'd144;

  typedef enum logic [2:0] {
    ACT_IGNORED   = 3'd0,
    ACT_ADDED     = 3'd1,
    ACT_DROPPED   = 3'd2,
    ACT_REMOVED   = 3'd3,
    ACT_NOT_FOUND = 3'd4
  } action_e;

  // broadcast to every cell for one accepted beat
  typedef struct packed {
    logic       upd;   // beat accepted this cycle
    logic       press; // note-on with non-zero velocity, list not full
    logic       rel;   // note-on with zero velocity
    logic [7:0] key;
  } cell_ctl_t;

endpackage

@@ sv/mhnl_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhnl_cell: one slot of the held-note list
// Holds a note, flags a match to its right neighbour, takes the neighbour's
// note when an entry at or before it is released; a tail slot loads a press.
// ----------------------------------------------------------------------------
module mhnl_cell (
  input  logic                clk_i,
  input  mhnl_pkg::cell_ctl_t ctl_i,
  input  logic                occupied_i, // slot lies below the count
  input  logic                tail_i,     // slot is the first free one
  input  logic                hit_seen_i, // match found in an older slot
  input  logic [7:0]          nb_note_i,  // note of the next newer slot
  output logic                hit_seen_o,
  output logic [7:0]          note_o
);

  logic [7:0] note_q;
  logic [7:0] note_d;

  assign hit_seen_o = hit_seen_i | (occupied_i & (note_q == ctl_i.key));
  assign note_o     = note_q;

  always_comb begin
    note_d = note_q;
    if (ctl_i.upd && ctl_i.press && tail_i) begin
      note_d = ctl_i.key;
    end else if (ctl_i.upd && ctl_i.rel && hit_seen_o) begin
      note_d = nb_note_i; // close the gap
    end
  end

  always_ff @(posedge clk_i) begin
    note_q <= note_d;
  end

endmodule

@@ sv/midi_held_note_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_held_note_list: ordered list of held MIDI notes, oldest first
// A row of cells keeps the list; note-on presses append, zero-velocity
// note-ons remove the oldest matching entry and shift later ones forward.
// ----------------------------------------------------------------------------
//
//  channel | direction | fields                                    | handshake
//  --------+-----------+-------------------------------------------+-----------------
//  in      | sink      | status_byte, note_number, velocity        | in_valid_i / in_stall_o
//  out     | source    | action, held_count, oldest_note, newest_note | out_valid_o / out_stall_i
//
//  One beat in gives one beat out in the next cycle. The cells and the count
//  update at the accepting edge; the result is read straight from them.
//  A new beat is taken in the cycle the pending result leaves, so the block
//  sustains one beat per cycle while the output is not stalled.
//  While the result is stalled the input is stalled and the list holds.
//  Reset clears the count and the output valid; note storage is not reset.
//
module midi_held_note_list (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] status_byte_i,
  input  logic [7:0] note_number_i,
  input  logic [7:0] velocity_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] action_o,
  output logic [3:0] held_count_o,
  output logic [7:0] oldest_note_o,
  output logic [7:0] newest_note_o
);

  localparam int unsigned N    = mhnl_pkg::MaxNotes;
  localparam int unsigned CntW = mhnl_pkg::CntW;

  logic                     accept;
  logic                     is_note_on;
  logic                     full;
  logic                     found;
  mhnl_pkg::cell_ctl_t      ctl;
  mhnl_pkg::action_e        act_d, act_q;
  logic [CntW-1:0]          count_d, count_q;
  logic                     out_valid_q;
  logic [N:0]               hit_chain;
  logic [N-1:0][7:0]        cell_note;
  logic [7:0]               newest;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_note_on = (status_byte_i == mhnl_pkg::NoteOnStatus);
  assign full       = (count_q >= CntW'(N));

  assign ctl.upd   = accept;
  assign ctl.press = is_note_on & (velocity_i != 8'd0) & ~full;
  assign ctl.rel   = is_note_on & (velocity_i == 8'd0);
  assign ctl.key   = note_number_i;

  // match flag ripples from oldest to newest slot
  assign hit_chain[0] = 1'b0;
  assign found        = hit_chain[N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [7:0] nb_note;
    if (i == N - 1) begin : g_last
      assign nb_note = note_number_i; // beyond the count after a removal
    end else begin : g_mid
      assign nb_note = cell_note[i+1];
    end
    mhnl_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occupied_i (count_q > CntW'(i)),
      .tail_i     (count_q == CntW'(i)),
      .hit_seen_i (hit_chain[i]),
      .nb_note_i  (nb_note),
      .hit_seen_o (hit_chain[i+1]),
      .note_o     (cell_note[i])
    );
  end

  always_comb begin
    act_d   = mhnl_pkg::ACT_IGNORED;
    count_d = count_q;
    if (is_note_on) begin
      if (velocity_i != 8'd0) begin
        if (full) begin
          act_d = mhnl_pkg::ACT_DROPPED;
        end else begin
          act_d   = mhnl_pkg::ACT_ADDED;
          count_d = count_q + CntW'(1);
        end
      end else if (found) begin
        act_d   = mhnl_pkg::ACT_REMOVED;
        count_d = count_q - CntW'(1);
      end else begin
        act_d = mhnl_pkg::ACT_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      act_q       <= mhnl_pkg::ACT_IGNORED;
    end else if (accept) begin
      count_q     <= count_d;
      out_valid_q <= 1'b1;
      act_q       <= act_d;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // newest entry sits in slot count-1
  always_comb begin
    newest = 8'd0;
    for (int i = 0; i < N; i++) begin
      if (count_q == CntW'(i + 1)) begin
        newest = cell_note[i];
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = act_q;
  assign held_count_o  = 4'(count_q);
  assign oldest_note_o = (count_q != '0) ? cell_note[0] : 8'd0;
  assign newest_note_o = newest;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for midi_held_note_list
// Note-on and other MIDI messages are sent as input beats. A local copy of
// the held-note list works out each reply. Reply beats are compared field by
// field in order, while both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;

  // one MIDI message as sent on the input channel
  typedef struct {
    logic [7:0] status;
    logic [7:0] note;
    logic [7:0] vel;
  } midi_msg_t;

  // what the block should report for one message
  typedef struct {
    mhnl_pkg::action_e action;
    logic [3:0]        count;
    logic [7:0]        oldest;
    logic [7:0]        newest;
  } list_report_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] status_byte_i = 8'd0;
  logic [7:0] note_number_i = 8'd0;
  logic [7:0] velocity_i    = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [2:0] action_o;
  logic [3:0] held_count_o;
  logic [7:0] oldest_note_o;
  logic [7:0] newest_note_o;

  midi_msg_t    midi_msgs_q[$];    // messages still to be sent
  list_report_t list_reports_q[$]; // replies owed by the block, oldest first
  logic [7:0]   held_keys[$];      // local copy of the list, oldest first
  int unsigned  fail_count = 0;
  int unsigned  cyc        = 0;
  logic         quiet;             // window with no idling on either side

  midi_held_note_list uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .status_byte_i (status_byte_i),
    .note_number_i (note_number_i),
    .velocity_i    (velocity_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .action_o      (action_o),
    .held_count_o  (held_count_o),
    .oldest_note_o (oldest_note_o),
    .newest_note_o (newest_note_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
  end

  // A window of the run with both sides flat out.
  assign quiet = (cyc >= 300) && (cyc < 700);

  // Applies one message to the local list and returns the reply it causes.
  // Only an exact note-on for channel 1 touches the list; zero velocity is a
  // release of the oldest matching entry, later entries close up behind it.
  function automatic list_report_t apply_midi_msg(midi_msg_t m);
    list_report_t r;
    int           hit;
    r.action = mhnl_pkg::ACT_IGNORED;
    hit      = -1;
    if (m.status == mhnl_pkg::NoteOnStatus) begin
      if (m.vel != 8'd0) begin
        if (held_keys.size() >= mhnl_pkg::MaxNotes) begin
          r.action = mhnl_pkg::ACT_DROPPED;
        end else begin
          held_keys.push_back(m.note);
          r.action = mhnl_pkg::ACT_ADDED;
        end
      end else begin
        foreach (held_keys[i]) begin
          if (hit < 0 && held_keys[i] == m.note) hit = i;
        end
        if (hit < 0) begin
          r.action = mhnl_pkg::ACT_NOT_FOUND;
        end else begin
          held_keys.delete(hit);
          r.action = mhnl_pkg::ACT_REMOVED;
        end
      end
    end
    r.count = 4'(held_keys.size());
    if (held_keys.size() == 0) begin
      r.oldest = 8'd0;
      r.newest = 8'd0;
    end else begin
      r.oldest = held_keys[0];
      r.newest = held_keys[held_keys.size() - 1];
    end
    return r;
  endfunction

  task automatic add_msg(input logic [7:0] status, input logic [7:0] note,
                         input logic [7:0] vel);
    midi_msg_t m;
    m.status = status;
    m.note   = note;
    m.vel    = vel;
    midi_msgs_q.push_back(m);
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Driver: loads the next message once the current beat has gone, or idles.
  // A stalled beat is held untouched.
  always @(posedge clk_i) begin : drive_msgs
    midi_msg_t m;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (midi_msgs_q.size() != 0 && (quiet || $urandom_range(99) >= 19)) begin
        m = midi_msgs_q.pop_front();
        status_byte_i <= m.status;
        note_number_i <= m.note;
        velocity_i    <= m.vel;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks the reply beat first, then books the reply owed for any
  // message taken at the same edge, so a stray reply never meets it.
  always @(posedge clk_i) begin : watch_list
    list_report_t exp_r;
    midi_msg_t    m;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (list_reports_q.size() == 0) begin
          $display("%0t: reply beat with none owed, action %0d count %0d",
                   $time, action_o, held_count_o);
          fail_count++;
        end else begin
          exp_r = list_reports_q.pop_front();
          check_field("action", 8'(exp_r.action), 8'(action_o));
          check_field("held_count", 8'(exp_r.count), 8'(held_count_o));
          check_field("oldest_note", exp_r.oldest, oldest_note_o);
          check_field("newest_note", exp_r.newest, newest_note_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        m.status = status_byte_i;
        m.note   = note_number_i;
        m.vel    = velocity_i;
        list_reports_q.push_back(apply_midi_msg(m));
      end
    end
    out_stall_i <= !quiet && ($urandom_range(99) < 19);
  end

  initial begin : stimulus
    int unsigned press_pct;
    int unsigned r;
    logic [7:0]  note;

    // directed opening: empty list, odd statuses, filling up, overflow,
    // duplicates and releases at the front, middle and back
    add_msg(mhnl_pkg::NoteOnStatus, 8'd60, 8'd0);    // release on an empty list
    add_msg(mhnl_pkg::NoteOnStatus, 8'd0, 8'd1);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd255, 8'd255);
    add_msg(8'd128, 8'd0, 8'd0);                     // note-off is not acted on
    add_msg(8'd0, 8'd255, 8'd255);
    add_msg(8'd255, 8'd0, 8'd127);
    add_msg(8'd145, 8'd60, 8'd64);                   // note-on, channel 2
    add_msg(8'd143, 8'd61, 8'd64);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd60, 8'd100);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd61, 8'd90);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd60, 8'd80);   // duplicate key
    add_msg(mhnl_pkg::NoteOnStatus, 8'd62, 8'd70);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd63, 8'd60);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd64, 8'd50);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd65, 8'd40);
    add_msg(mhnl_pkg::NoteOnStatus, 8'd66, 8'd30);   // list now full
    add_msg(mhnl_pkg::NoteOnStatus, 8'd70, 8'd100);  // dropped
    add_msg(mhnl_pkg::NoteOnStatus, 8'd60, 8'd0);    // first of the pair goes
    add_msg(mhnl_pkg::NoteOnStatus, 8'd0, 8'd0);     // oldest
    add_msg(mhnl_pkg::NoteOnStatus, 8'd66, 8'd0);    // newest
    add_msg(mhnl_pkg::NoteOnStatus, 8'd99, 8'd0);    // no match, list not empty
    add_msg(mhnl_pkg::NoteOnStatus, 8'd60, 8'd0);    // second of the pair
    add_msg(mhnl_pkg::NoteOnStatus, 8'd255, 8'd0);

    // random part: mostly note-on traffic on a small set of keys so releases
    // find their notes, with the press share swinging to fill and drain
    press_pct = 50;
    for (int i = 0; i < 950; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(2))
          0: press_pct = 25;
          1: press_pct = 50;
          default: press_pct = 80;
        endcase
      end
      r = $urandom_range(99);
      if (r < 8) begin
        add_msg(8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
      end else if (r < 12) begin
        add_msg(mhnl_pkg::NoteOnStatus, 8'($urandom_range(255)),
                8'($urandom_range(255)));
      end else begin
        note = ($urandom_range(99) < 15) ? 8'($urandom_range(255))
                                         : 8'(40 + $urandom_range(7));
        if ($urandom_range(99) < press_pct) begin
          add_msg(mhnl_pkg::NoteOnStatus, note, 8'($urandom_range(255, 1)));
        end else begin
          add_msg(mhnl_pkg::NoteOnStatus, note, 8'd0);
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: every message sent, every reply back, then a short margin;
    // sampled mid-cycle so the clocked blocks have settled
    while (midi_msgs_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (list_reports_q.size() != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
